[rtl/opd_pkg.sv]
package opd_pkg;

  // page layout
  localparam int unsigned HeaderLen  = 27;
  localparam int unsigned LaceMax    = 255;
  // non-empty packets a page can hold
  localparam int unsigned TableSlots = 255;
  // size table storage, power of two so the address wraps cleanly
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  // result roles
  localparam logic [1:0] RoleHeader = 2'd0;
  localparam logic [1:0] RoleLacing = 2'd1;
  localparam logic [1:0] RoleData   = 2'd2;

  // header field codes
  localparam logic [2:0] FldSignature = 3'd0;
  localparam logic [2:0] FldVersion   = 3'd1;
  localparam logic [2:0] FldFlags     = 3'd2;
  localparam logic [2:0] FldGranule   = 3'd3;
  localparam logic [2:0] FldSerial    = 3'd4;
  localparam logic [2:0] FldSequence  = 3'd5;
  localparam logic [2:0] FldChecksum  = 3'd6;
  localparam logic [2:0] FldSegCount  = 3'd7;

  typedef struct packed {
    logic [2:0] field;
    logic [2:0] offset;
  } opd_hdr_pos_t;

  // one size table entry: packet number and packet length
  typedef struct packed {
    logic [7:0]  pnum;
    logic [15:0] size;
  } opd_entry_t;

  typedef struct packed {
    logic [1:0]  role;
    logic [2:0]  header_field;
    logic [2:0]  field_byte;
    logic [7:0]  byte_echo;
    logic [7:0]  packet_number;
    logic [15:0] packet_len;
    logic        size_done;
    logic        packet_last;
    logic        page_last;
    logic [31:0] page_count;
  } opd_result_t;

  // header byte index to field and little-endian byte offset
  function automatic opd_hdr_pos_t opd_map_header(input logic [4:0] idx);
    opd_hdr_pos_t pos;
    pos = '0;
    if (idx < 5'd4) begin
      pos.field  = FldSignature;
      pos.offset = idx[2:0];
    end else if (idx == 5'd4) begin
      pos.field  = FldVersion;
    end else if (idx == 5'd5) begin
      pos.field  = FldFlags;
    end else if (idx < 5'd14) begin
      pos.field  = FldGranule;
      pos.offset = 3'(idx - 5'd6);
    end else if (idx < 5'd18) begin
      pos.field  = FldSerial;
      pos.offset = 3'(idx - 5'd14);
    end else if (idx < 5'd22) begin
      pos.field  = FldSequence;
      pos.offset = 3'(idx - 5'd18);
    end else if (idx < 5'd26) begin
      pos.field  = FldChecksum;
      pos.offset = 3'(idx - 5'd22);
    end else begin
      pos.field  = FldSegCount;
    end
    return pos;
  endfunction

endpackage

[rtl/opd_if.sv]
// input byte channel
interface opd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// labeled byte channel
interface opd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  role;
  logic [2:0]  header_field;
  logic [2:0]  field_byte;
  logic [7:0]  byte_echo;
  logic [7:0]  packet_number;
  logic [15:0] packet_len;
  logic        size_done;
  logic        packet_last;
  logic        page_last;
  logic [31:0] page_count;

  modport source (
    output valid, output role, output header_field, output field_byte,
    output byte_echo, output packet_number, output packet_len,
    output size_done, output packet_last, output page_last, output page_count,
    input ready
  );
  modport sink (
    input valid, input role, input header_field, input field_byte,
    input byte_echo, input packet_number, input packet_len,
    input size_done, input packet_last, input page_last, input page_count,
    output ready
  );
endinterface

[rtl/ogg_page_deframer.sv]
// Ogg page deframer: labels every byte of an Ogg stream as a header field
// byte, a lacing value or a packet data byte, one result per input byte.
// Lacing values are summed into packet sizes; each non-empty packet's size
// and number go into a 256-entry size table memory (one write port, one
// registered read port) while the lacing values stream in, and are read
// back in order while the data bytes pass. The block takes one byte per
// clock cycle in every phase with no bubbles while its results are taken: the read port always
// prefetches the entry after the current packet, so a packet boundary
// (even a run of one-byte packets) never waits for the memory. A same-cycle
// write and read of one entry is forwarded. Results leave through one output
// register; a new request is taken in the cycle the held result is taken.
// The size table needs no clearing after reset; reset alone readies the block.
module ogg_page_deframer (
  input  logic      clk,
  input  logic      rst_n,
  opd_in_if.sink    in_ch,
  opd_out_if.source out_ch
);
  import opd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LACING = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [4:0]            header_index_r, header_index_nxt;
  logic [7:0]            segment_total_r, segment_total_nxt;
  logic [7:0]            segment_index_r, segment_index_nxt;
  logic [15:0]           running_size_r, running_size_nxt;
  logic [7:0]            packet_counter_r, packet_counter_nxt;
  logic [7:0]            nonempty_count_r, nonempty_count_nxt;
  logic [TableAw-1:0]    read_index_r, read_index_nxt;
  logic [15:0]           bytes_left_r, bytes_left_nxt;
  logic [7:0]            cur_pnum_r, cur_pnum_nxt;
  opd_entry_t            first_entry_r, first_entry_nxt;
  logic [31:0]           page_counter_r, page_counter_nxt;
  logic                  out_valid_r, out_valid_nxt;
  opd_result_t           out_res_r, out_res_nxt;

  opd_entry_t            size_mem [TableDepth];
  opd_entry_t            rdata_r;
  logic [TableAw-1:0]    raddr;
  logic [TableAw-1:0]    waddr;
  logic                  wen;
  opd_entry_t            wdata;

  logic                  in_ready;
  logic                  acc;
  logic                  page_end;

  // lacing phase helpers
  logic [15:0]           lace_size;
  logic [7:0]            lace_seg;
  logic                  lace_done;
  logic                  lace_last;
  logic                  lace_store;
  logic [7:0]            lace_nonempty;
  opd_hdr_pos_t          hdr_pos;
  logic [4:0]            hdr_idx;
  logic                  data_end;

  // output register takes a new result when empty or being drained
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  assign lace_size     = running_size_r + 16'(in_ch.data_byte);
  assign lace_seg      = segment_index_r + 8'd1;
  assign lace_last     = (lace_seg >= segment_total_r);
  assign lace_done     = (in_ch.data_byte < 8'(LaceMax)) || lace_last;
  assign lace_store    = lace_done && (lace_size != 16'd0) &&
                         (nonempty_count_r < 8'(TableSlots));
  assign lace_nonempty = lace_store ? nonempty_count_r + 8'd1 : nonempty_count_r;
  assign hdr_idx       = (header_index_r >= 5'(HeaderLen)) ? 5'(HeaderLen - 1)
                                                           : header_index_r;
  assign hdr_pos       = opd_map_header(hdr_idx);
  assign data_end      = (bytes_left_r == 16'd1);

  // table write during the lacing phase
  assign wen         = acc && (phase_r == PH_LACING) && lace_store;
  assign waddr       = nonempty_count_r;
  assign wdata.pnum  = packet_counter_r;
  assign wdata.size  = lace_size;

  // read port always holds the entry after the current packet
  always_comb begin
    if (phase_r == PH_DATA) begin
      raddr = (acc && data_end) ? read_index_r + TableAw'(2) : read_index_r + TableAw'(1);
    end else begin
      raddr = TableAw'(1);
    end
  end

  // next state and result
  always_comb begin
    phase_nxt          = phase_r;
    header_index_nxt   = header_index_r;
    segment_total_nxt  = segment_total_r;
    segment_index_nxt  = segment_index_r;
    running_size_nxt   = running_size_r;
    packet_counter_nxt = packet_counter_r;
    nonempty_count_nxt = nonempty_count_r;
    read_index_nxt     = read_index_r;
    bytes_left_nxt     = bytes_left_r;
    cur_pnum_nxt       = cur_pnum_r;
    first_entry_nxt    = first_entry_r;
    page_counter_nxt   = page_counter_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_res_nxt        = out_res_r;
    page_end           = 1'b0;

    if (acc) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt            = '0;
      out_res_nxt.byte_echo  = in_ch.data_byte;
      out_res_nxt.page_count = page_counter_r;

      case (phase_r)
        PH_LACING: begin
          out_res_nxt.role          = RoleLacing;
          out_res_nxt.packet_number = packet_counter_r;
          segment_index_nxt         = lace_seg;
          running_size_nxt          = lace_size;
          nonempty_count_nxt        = lace_nonempty;
          if (wen && (nonempty_count_r == 8'd0)) begin
            first_entry_nxt = wdata;
          end
          if (lace_done) begin
            out_res_nxt.size_done  = 1'b1;
            out_res_nxt.packet_len = lace_size;
            packet_counter_nxt     = packet_counter_r + 8'd1;
            running_size_nxt       = 16'd0;
          end
          if (lace_last) begin
            if (lace_nonempty == 8'd0) begin
              page_end = 1'b1;
            end else begin
              phase_nxt      = PH_DATA;
              read_index_nxt = '0;
              // entry zero may be written in this very cycle
              if (wen && (nonempty_count_r == 8'd0)) begin
                cur_pnum_nxt   = wdata.pnum;
                bytes_left_nxt = wdata.size;
              end else begin
                cur_pnum_nxt   = first_entry_r.pnum;
                bytes_left_nxt = first_entry_r.size;
              end
            end
          end
        end
        PH_DATA: begin
          out_res_nxt.role          = RoleData;
          out_res_nxt.packet_number = cur_pnum_r;
          bytes_left_nxt            = bytes_left_r - 16'd1;
          if (data_end) begin
            out_res_nxt.packet_last = 1'b1;
            read_index_nxt          = read_index_r + TableAw'(1);
            if (read_index_r + TableAw'(1) >= nonempty_count_r) begin
              page_end = 1'b1;
            end else begin
              cur_pnum_nxt   = rdata_r.pnum;
              bytes_left_nxt = rdata_r.size;
            end
          end
        end
        default: begin
          out_res_nxt.role         = RoleHeader;
          out_res_nxt.header_field = hdr_pos.field;
          out_res_nxt.field_byte   = hdr_pos.offset;
          if (hdr_idx == 5'(HeaderLen - 1)) begin
            segment_total_nxt  = in_ch.data_byte;
            segment_index_nxt  = 8'd0;
            running_size_nxt   = 16'd0;
            packet_counter_nxt = 8'd0;
            nonempty_count_nxt = 8'd0;
            read_index_nxt     = '0;
            bytes_left_nxt     = 16'd0;
            header_index_nxt   = 5'd0;
            if (in_ch.data_byte == 8'd0) begin
              page_end = 1'b1;
            end else begin
              phase_nxt = PH_LACING;
            end
          end else begin
            phase_nxt        = PH_HEADER;
            header_index_nxt = hdr_idx + 5'd1;
          end
        end
      endcase

      // page close returns to the header
      if (page_end) begin
        out_res_nxt.page_last = 1'b1;
        phase_nxt             = PH_HEADER;
        header_index_nxt      = 5'd0;
        page_counter_nxt      = page_counter_r + 32'd1;
      end
    end
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_HEADER;
      header_index_r     <= 5'd0;
      segment_total_r    <= 8'd0;
      segment_index_r    <= 8'd0;
      running_size_r     <= 16'd0;
      packet_counter_r   <= 8'd0;
      nonempty_count_r   <= 8'd0;
      read_index_r       <= '0;
      bytes_left_r       <= 16'd0;
      cur_pnum_r         <= 8'd0;
      first_entry_r      <= '0;
      page_counter_r     <= 32'd0;
      out_valid_r        <= 1'b0;
      out_res_r          <= '0;
    end else begin
      phase_r            <= phase_nxt;
      header_index_r     <= header_index_nxt;
      segment_total_r    <= segment_total_nxt;
      segment_index_r    <= segment_index_nxt;
      running_size_r     <= running_size_nxt;
      packet_counter_r   <= packet_counter_nxt;
      nonempty_count_r   <= nonempty_count_nxt;
      read_index_r       <= read_index_nxt;
      bytes_left_r       <= bytes_left_nxt;
      cur_pnum_r         <= cur_pnum_nxt;
      first_entry_r      <= first_entry_nxt;
      page_counter_r     <= page_counter_nxt;
      out_valid_r        <= out_valid_nxt;
      out_res_r          <= out_res_nxt;
    end
  end

  // size table, write-first forwarding on a same-entry access
  always_ff @(posedge clk) begin
    if (wen) begin
      size_mem[waddr] <= wdata;
    end
    if (wen && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= size_mem[raddr];
    end
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.role          = out_res_r.role;
  assign out_ch.header_field  = out_res_r.header_field;
  assign out_ch.field_byte    = out_res_r.field_byte;
  assign out_ch.byte_echo     = out_res_r.byte_echo;
  assign out_ch.packet_number = out_res_r.packet_number;
  assign out_ch.packet_len    = out_res_r.packet_len;
  assign out_ch.size_done     = out_res_r.size_done;
  assign out_ch.packet_last   = out_res_r.packet_last;
  assign out_ch.page_last     = out_res_r.page_last;
  assign out_ch.page_count    = out_res_r.page_count;

  // a packet in flight always has bytes left
  a_data_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_left_r != 16'd0))
    else $error("data phase with no bytes left");

  // the packet being read is one that was stored
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (read_index_r < nonempty_count_r))
    else $error("size table read past stored packets");

  // a closing byte advances the page count and returns to the header
  a_page_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && page_end) |=>
      (page_counter_r == $past(page_counter_r) + 32'd1) && (phase_r == PH_HEADER))
    else $error("page close did not advance page count");

  // only lacing values close packet sizes
  a_size_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.size_done) |-> (out_res_r.role == RoleLacing))
    else $error("size closed outside lacing");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import opd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongStall  = 400;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned StageBytes = 60;

  // parser phases of the predictor
  typedef enum logic [1:0] {
    InHeader,
    InLacing,
    InData
  } parse_phase_t;

  // one directed page: segment count, up to four lacing values, fill byte,
  // and optionally the label of the byte that ends the page
  typedef struct {
    logic [7:0]  segs;
    logic [31:0] laces;
    logic [7:0]  fill;
    bit          typed;
    opd_result_t page_end;
  } page_row_t;

  logic clk = 1'b0;
  logic rst_n;

  opd_in_if  in_ch();
  opd_out_if out_ch();

  ogg_page_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  parse_phase_t parse_phase = InHeader;
  logic [4:0]   hdr_pos      = '0;
  logic [7:0]   seg_total    = '0;
  logic [7:0]   seg_seen     = '0;
  logic [15:0]  run_len      = '0;
  logic [7:0]   pkt_idx      = '0;
  logic [7:0]   filled_slots = '0;
  logic [7:0]   rd_slot      = '0;
  logic [15:0]  left_in_pkt  = '0;
  opd_entry_t   pkt_sizes [TableSlots];
  logic [31:0]  page_idx     = '0;

  opd_result_t  labels_due [$];
  logic [7:0]   lace_buf [255];

  int          mismatches   = 0;
  int          bytes_sent   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned stall_asked  = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;

  page_row_t directed_pages [9] = '{
    // zero segment count, all-zero header
    '{8'd0, 32'h0, 8'h00, 1'b1,
      '{RoleHeader, FldSegCount, 3'd0, 8'h00, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1, 32'd0}},
    // zero segment count, all-ones header
    '{8'd0, 32'h0, 8'hFF, 1'b1,
      '{RoleHeader, FldSegCount, 3'd0, 8'h00, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1, 32'd1}},
    // all packets empty: last lacing value ends the page
    '{8'd3, 32'h0, 8'h0F, 1'b1,
      '{RoleLacing, 3'd0, 3'd0, 8'h00, 8'd2, 16'd0, 1'b1, 1'b0, 1'b1, 32'd2}},
    // two full segments closed by the last segment
    '{8'd2, 32'h0000_FFFF, 8'h5A, 1'b1,
      '{RoleData, 3'd0, 3'd0, 8'h5A, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1, 32'd3}},
    // full segment closed by a zero
    '{8'd2, 32'h0000_00FF, 8'hA5, 1'b1,
      '{RoleData, 3'd0, 3'd0, 8'hA5, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1, 32'd4}},
    // one-byte packets around an empty one, then 254
    '{8'd4, 32'hFE01_0001, 8'h00, 1'b1,
      '{RoleData, 3'd0, 3'd0, 8'h00, 8'd3, 16'd0, 1'b0, 1'b1, 1'b1, 32'd5}},
    // shortest page carrying data
    '{8'd1, 32'h0000_0001, 8'hFF, 1'b1,
      '{RoleData, 3'd0, 3'd0, 8'hFF, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1, 32'd6}},
    // single 255 segment closed by page end
    '{8'd1, 32'h0000_00FF, 8'hF0, 1'b0, '0},
    // empty packet first, then 255 + 3
    '{8'd3, 32'h0003_FF00, 8'h3C, 1'b0, '0}
  };

  always #5 clk = ~clk;

  // page done: back to header, bump page number
  function automatic void next_page();
    parse_phase = InHeader;
    hdr_pos     = '0;
    page_idx    = page_idx + 32'd1;
  endfunction

  // label one accepted byte and advance the parser state
  function automatic opd_result_t label_byte(input logic [7:0] b);
    opd_result_t r;
    logic        closes;
    r            = '0;
    r.byte_echo  = b;
    r.page_count = page_idx;
    case (parse_phase)
      InLacing: begin
        r.role          = RoleLacing;
        r.packet_number = pkt_idx;
        run_len         = run_len + {8'd0, b};
        seg_seen        = seg_seen + 8'd1;
        closes          = (b < 8'(LaceMax)) || (seg_seen >= seg_total);
        if (closes) begin
          r.size_done  = 1'b1;
          r.packet_len = run_len;
          if (run_len != 16'd0 && filled_slots < 8'(TableSlots)) begin
            pkt_sizes[filled_slots] = '{pkt_idx, run_len};
            filled_slots            = filled_slots + 8'd1;
          end
          pkt_idx = pkt_idx + 8'd1;
          run_len = '0;
        end
        if (seg_seen >= seg_total) begin
          if (filled_slots == 8'd0) begin
            r.page_last = 1'b1;
            next_page();
          end else begin
            parse_phase = InData;
            rd_slot     = '0;
            left_in_pkt = pkt_sizes[0].size;
          end
        end
      end
      InData: begin
        r.role          = RoleData;
        r.packet_number = pkt_sizes[rd_slot].pnum;
        left_in_pkt     = left_in_pkt - 16'd1;
        if (left_in_pkt == 16'd0) begin
          r.packet_last = 1'b1;
          rd_slot       = rd_slot + 8'd1;
          if (rd_slot >= filled_slots) begin
            r.page_last = 1'b1;
            next_page();
          end else begin
            left_in_pkt = pkt_sizes[rd_slot].size;
          end
        end
      end
      default: begin
        r.role = RoleHeader;
        if (hdr_pos < 5'd4) begin
          r.header_field = FldSignature;
          r.field_byte   = hdr_pos[2:0];
        end else if (hdr_pos < 5'd6) begin
          r.header_field = (hdr_pos == 5'd4) ? FldVersion : FldFlags;
        end else if (hdr_pos < 5'd14) begin
          r.header_field = FldGranule;
          r.field_byte   = 3'(hdr_pos - 5'd6);
        end else if (hdr_pos < 5'd18) begin
          r.header_field = FldSerial;
          r.field_byte   = 3'(hdr_pos - 5'd14);
        end else if (hdr_pos < 5'd22) begin
          r.header_field = FldSequence;
          r.field_byte   = 3'(hdr_pos - 5'd18);
        end else if (hdr_pos < 5'd26) begin
          r.header_field = FldChecksum;
          r.field_byte   = 3'(hdr_pos - 5'd22);
        end else begin
          r.header_field = FldSegCount;
        end
        if (hdr_pos >= 5'(HeaderLen - 1)) begin
          // segment count: start a fresh page layout
          seg_total    = b;
          seg_seen     = '0;
          run_len      = '0;
          pkt_idx      = '0;
          filled_slots = '0;
          rd_slot      = '0;
          left_in_pkt  = '0;
          if (b == 8'd0) begin
            r.page_last = 1'b1;
            next_page();
          end else begin
            parse_phase = InLacing;
            hdr_pos     = '0;
          end
        end else begin
          hdr_pos = hdr_pos + 5'd1;
        end
      end
    endcase
    return r;
  endfunction

  // offer one byte, wait for the request to be taken, then maybe go idle
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input opd_result_t page_end);
    opd_result_t guess;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    guess = label_byte(b);
    labels_due.insert(labels_due.size(), typed ? page_end : guess);
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // one whole page: header, lacing values from lace_buf, packet data
  task automatic send_page(input logic [7:0] segs, input bit scramble,
                           input logic [7:0] fill, input bit typed,
                           input opd_result_t page_end);
    int data_total;
    int k;
    data_total = 0;
    for (k = 0; k < segs; k++) data_total += lace_buf[k];
    for (k = 0; k < int'(HeaderLen) - 1; k++)
      send_byte(scramble ? 8'($urandom) : fill, 1'b0, page_end);
    send_byte(segs, typed && segs == 8'd0, page_end);
    for (k = 0; k < segs; k++)
      send_byte(lace_buf[k], typed && data_total == 0 && k == segs - 1, page_end);
    for (k = 0; k < data_total; k++)
      send_byte(scramble ? 8'($urandom) : fill, typed && k == data_total - 1, page_end);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served <= stall_asked;
      stall_left   <= LongStall;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each taken result with the oldest pending label
  always @(posedge clk) begin
    opd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (labels_due.size() == 0) begin
        $display("%0t: result expected none, got byte %0h", $time, out_ch.byte_echo);
        mismatches++;
      end else begin
        want = labels_due.pop_front();
        check_field("role", 32'(want.role), 32'(out_ch.role));
        check_field("header_field", 32'(want.header_field), 32'(out_ch.header_field));
        check_field("field_byte", 32'(want.field_byte), 32'(out_ch.field_byte));
        check_field("byte_echo", 32'(want.byte_echo), 32'(out_ch.byte_echo));
        check_field("packet_number", 32'(want.packet_number), 32'(out_ch.packet_number));
        check_field("packet_len", 32'(want.packet_len), 32'(out_ch.packet_len));
        check_field("size_done", 32'(want.size_done), 32'(out_ch.size_done));
        check_field("packet_last", 32'(want.packet_last), 32'(out_ch.packet_last));
        check_field("page_last", 32'(want.page_last), 32'(out_ch.page_last));
        check_field("page_count", want.page_count, out_ch.page_count);
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[ogg_page_deframer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          i;
    int          stage;
    int          goal_base;
    int          page_no;
    int          pick;
    logic [7:0]  segs;
    bit          dense;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'd0;
    send_idle_pct = 8;
    recv_idle_pct = 88;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pages
    foreach (directed_pages[row]) begin
      for (i = 0; i < directed_pages[row].segs; i++)
        lace_buf[i] = directed_pages[row].laces[8*i +: 8];
      send_page(directed_pages[row].segs, 1'b0, directed_pages[row].fill,
                directed_pages[row].typed, directed_pages[row].page_end);
    end

    // random pages in three idling stages
    page_no   = 0;
    for (stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 8 : (stage == 1) ? 88 : 0;
      recv_idle_pct = (stage == 0) ? 88 : (stage == 1) ? 8 : 0;
      // fill the block up behind a long receiver hold-off
      if (stage == 2) stall_asked++;
      goal_base = bytes_sent;
      while (bytes_sent < goal_base + int'(StageBytes)) begin
        page_no++;
        if (page_no % 12 == 2) begin
          // full segment table; first one fills every size slot
          segs  = 8'd255;
          dense = (page_no == 2);
          for (i = 0; i < 255; i++)
            lace_buf[i] = dense ? 8'd1 : 8'($urandom_range(1));
        end else begin
          pick = $urandom_range(99);
          segs = (pick < 6) ? 8'd0 : 8'($urandom_range(1, 6));
          for (i = 0; i < segs; i++) begin
            pick = $urandom_range(99);
            lace_buf[i] = (pick < 6)  ? 8'd255 :
                          (pick < 16) ? 8'd0 :
                          (pick < 20) ? 8'($urandom_range(255)) :
                                        8'($urandom_range(1, 6));
          end
        end
        send_page(segs, 1'b1, 8'd0, 1'b0, '0);
      end
      // after the first stage the sender pauses until the block has drained
      if (stage == 0) begin
        in_ch.valid <= 1'b0;
        while (labels_due.size() != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    while (labels_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ogg_page_deframer] OK");
    end else begin
      $display("[ogg_page_deframer] ERROR");
    end
    $finish;
  end

endmodule
